// ===== hdl/matrix_keypad_debounce_assert.svh =====
// assertion macros for the keypad debounce checker
// expects clk and rst_n to be visible where a macro is used
`ifndef MATRIX_KEYPAD_DEBOUNCE_ASSERT_SVH
`define MATRIX_KEYPAD_DEBOUNCE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MKD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keypad debounce check failed");

// next-cycle implication, disabled in reset
`define MKD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keypad debounce check failed");

`endif

// ===== hdl/mkd_pkg.sv =====
// shared types, constants and the key character table for the keypad debounce
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

    localparam int CODE_W    = 5;
    localparam int CHAR_W    = 7;
    localparam int LEVELS_W  = 16;
    localparam int TICKS_W   = 8;
    localparam int ROWS_DEF  = 4;
    localparam int COLS_DEF  = 4;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd3;

    // item kinds
    localparam logic REQ_POLL = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef logic [CODE_W-1:0]   code_t;
    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [TICKS_W-1:0]  ticks_t;
    typedef logic [LEVELS_W-1:0] levels_t;

    // one decoded word handed to the state machine
    typedef struct packed {
        logic  tick;
        code_t code;
    } mkd_item_t;

    // ascii of a key code, 0 for codes without a character
    function automatic char_t char_of_code(input code_t code);
        char_t c;
        case (code)
            5'd2:    c = 7'h39;
            5'd3:    c = 7'h38;
            5'd4:    c = 7'h37;
            5'd6:    c = 7'h36;
            5'd7:    c = 7'h35;
            5'd8:    c = 7'h34;
            5'd10:   c = 7'h33;
            5'd11:   c = 7'h32;
            5'd12:   c = 7'h31;
            5'd14:   c = 7'h45;
            5'd15:   c = 7'h53;
            5'd16:   c = 7'h30;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/matrix_keypad_debounce.sv =====
// top level of the debounced matrix keypad scanner
// depends on mkd_pkg, mkd_encoder, mkd_fsm
//
// channel   | handshake          | payload
// ----------+--------------------+-----------------------------
// in        | in_valid/in_stall  | req_type, row_levels
// out       | out_valid/out_stall| key_code, key_char
// config    | cfg_wr_en          | cfg_wr_data (debounce ticks)
//
// a result word is registered first in the input register, then in the output register once that is free
// one word per cycle sustained while out_stall is low: input register, encoder and fsm, result register
// the input side stalls only while a result sits in the output register under stall
// reset (rst_n, async) puts the fsm in scan with cleared code and countdown, ticks = 3
`timescale 1ns / 1ps
`default_nettype none

module matrix_keypad_debounce #(
    parameter int ROWS = mkd_pkg::ROWS_DEF,
    parameter int COLS = mkd_pkg::COLS_DEF
) (
    input  wire                    clk,
    input  wire                    rst_n,
    // input words
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire                    req_type,
    input  wire mkd_pkg::levels_t  row_levels,
    // result words
    output logic                   out_valid,
    input  wire                    out_stall,
    output mkd_pkg::code_t         key_code,
    output mkd_pkg::char_t         key_char,
    // debounce tick count register
    input  wire                    cfg_wr_en,
    input  wire mkd_pkg::ticks_t   cfg_wr_data
);

    // config register
    mkd_pkg::ticks_t ticks_reg;

    // input register stage
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_type_reg;
    mkd_pkg::levels_t s1_levels_reg;

    // result register stage
    logic             out_valid_reg, out_valid_next;
    mkd_pkg::code_t   out_code_reg;
    mkd_pkg::char_t   out_char_reg;

    logic               out_free;
    logic               s1_adv;
    logic               in_take;
    mkd_pkg::code_t     raw_code;
    mkd_pkg::code_t     report;
    mkd_pkg::mkd_item_t item;

    // the output register can take a new word when empty or being emptied
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    mkd_encoder #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_encoder (
        .levels (s1_levels_reg),
        .code   (raw_code)
    );

    // ticks are decoded the same as polls; the fsm ignores the code then
    assign item.tick = (s1_type_reg == mkd_pkg::REQ_TICK);
    assign item.code = raw_code;

    // state moves only when the word leaves the input register
    mkd_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_adv),
        .item   (item),
        .ticks  (ticks_reg),
        .report (report)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg     <= mkd_pkg::TICKS_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ticks_reg <= cfg_wr_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_type_reg   <= req_type;
            s1_levels_reg <= row_levels;
        end
        if (s1_adv)
        begin
            out_code_reg <= report;
            out_char_reg <= mkd_pkg::char_of_code(report);
        end
    end

    assign out_valid = out_valid_reg;
    assign key_code  = out_code_reg;
    assign key_char  = out_char_reg;

endmodule

`default_nettype wire

// ===== hdl/mkd_encoder.sv =====
// priority encoder: lowest column, then lowest row, of the active-low levels
// depends on mkd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mkd_encoder #(
    parameter int ROWS = mkd_pkg::ROWS_DEF,
    parameter int COLS = mkd_pkg::COLS_DEF
) (
    input  wire mkd_pkg::levels_t levels,
    output mkd_pkg::code_t        code
);

    // positions past the field width count as released
    localparam int NPOS = (ROWS * COLS < mkd_pkg::LEVELS_W) ? ROWS * COLS : mkd_pkg::LEVELS_W;

    always_comb
    begin
        code = '0;
        for (int p = NPOS - 1; p >= 0; p--)
        begin
            if (!levels[p])
            begin
                code = mkd_pkg::code_t'(p + 1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mkd_fsm.sv =====
// scan / confirm / pressed state machine with the debounce countdown
// depends on mkd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mkd_fsm (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  step,
    input  wire mkd_pkg::mkd_item_t item,
    input  wire mkd_pkg::ticks_t  ticks,
    output mkd_pkg::code_t        report
);

    localparam logic [1:0] MODE_SCAN    = 2'd0;
    localparam logic [1:0] MODE_CONFIRM = 2'd1;
    localparam logic [1:0] MODE_PRESSED = 2'd2;

    logic [1:0]      mode_reg, mode_next;
    mkd_pkg::code_t  held_reg, held_next;
    mkd_pkg::ticks_t count_reg, count_next;

    always_comb
    begin
        mode_next  = mode_reg;
        held_next  = held_reg;
        count_next = count_reg;
        report     = '0;
        if (item.tick)
        begin
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
        end
        else
        begin
            case (mode_reg)
                MODE_CONFIRM:
                begin
                    if (count_reg == '0)
                    begin
                        if (item.code == held_reg)
                        begin
                            report    = item.code;
                            mode_next = MODE_PRESSED;
                        end
                        else
                        begin
                            mode_next = MODE_SCAN;
                        end
                    end
                end
                MODE_PRESSED:
                begin
                    if (item.code != held_reg)
                    begin
                        mode_next = MODE_SCAN;
                    end
                end
                default:
                begin
                    // scan, and the unused code behaves the same
                    mode_next  = MODE_SCAN;
                    count_next = '0;
                    if (item.code != '0)
                    begin
                        count_next = ticks;
                        held_next  = item.code;
                        mode_next  = MODE_CONFIRM;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SCAN;
            held_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/mkd_checker.sv =====
// port-level checker for the keypad debounce, bound to the top level
// depends on mkd_pkg and matrix_keypad_debounce_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_keypad_debounce_assert.svh"

module mkd_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   in_stall,
    input wire                   out_valid,
    input wire                   out_stall,
    input wire mkd_pkg::code_t   key_code,
    input wire mkd_pkg::char_t   key_char
);

    logic key_unmapped;

    // keys with no character on the legend
    assign key_unmapped = (key_code == 5'd1) || (key_code == 5'd5)
                       || (key_code == 5'd9) || (key_code == 5'd13);

    // a stalled result word holds
    `MKD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({key_code, key_char}))

    // input side only stalls behind a blocked result
    `MKD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

    // no character without a key, and codes stay in range
    `MKD_ASSERT_NOW(a_char_needs_code, out_valid && key_code == 5'd0, key_char == 7'd0)
    `MKD_ASSERT_NOW(a_code_range, out_valid, key_code <= 5'd16)

    `MKD_ASSERT_NOW(a_unmapped, out_valid && key_unmapped, key_char == 7'd0)

endmodule

bind matrix_keypad_debounce mkd_checker u_mkd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .key_code  (key_code),
    .key_char  (key_char)
);

`default_nettype wire

// ===== test/matrix_keypad_debounce_test.sv =====
// self-checking testbench for the debounced matrix keypad scanner
// drives polls and timer ticks, predicts each result word and compares it field by field
// depends on mkd_pkg and matrix_keypad_debounce
`timescale 1ns / 1ps

module matrix_keypad_debounce_test;

    import mkd_pkg::*;

    // no acceptance on any port for this many cycles ends the run
    localparam int STALL_LIMIT = 2000;

    typedef enum logic [1:0] {
        KM_SCAN    = 2'd0,
        KM_CONFIRM = 2'd1,
        KM_PRESSED = 2'd2
    } key_mode_t;

    typedef struct packed {
        code_t code;
        char_t ascii;
    } key_report_t;

    // one directed word; typed marks a row whose result is written out by hand
    typedef struct packed {
        logic    kind;
        levels_t levels;
        logic    typed;
        code_t   code;
        char_t   ascii;
    } stim_row_t;

    // ascii per key code, keypad layout 789A / 456B / 123C / 0SED, first column unmapped
    localparam char_t KEY_ASCII [0:16] = '{
        7'h00,
        7'h00, 7'h39, 7'h38, 7'h37,
        7'h00, 7'h36, 7'h35, 7'h34,
        7'h00, 7'h33, 7'h32, 7'h31,
        7'h00, 7'h45, 7'h53, 7'h30
    };

    // directed words, run at the reset debounce count of 3
    localparam stim_row_t DIRECTED_WORDS [0:23] = '{
        '{REQ_POLL, 16'hFFFF, 1'b1, 5'd0,  7'h00},  // nothing down after reset
        '{REQ_TICK, 16'h0000, 1'b1, 5'd0,  7'h00},  // tick with countdown already at zero
        '{REQ_POLL, 16'h0000, 1'b0, 5'd0,  7'h00},  // every key down, lowest wins
        '{REQ_POLL, 16'h0000, 1'b0, 5'd0,  7'h00},  // poll during countdown
        '{REQ_TICK, 16'h0000, 1'b0, 5'd0,  7'h00},
        '{REQ_TICK, 16'h0000, 1'b0, 5'd0,  7'h00},
        '{REQ_TICK, 16'h0000, 1'b0, 5'd0,  7'h00},
        '{REQ_POLL, 16'h0000, 1'b1, 5'd1,  7'h00},  // first key confirmed, no character
        '{REQ_POLL, 16'h0000, 1'b0, 5'd0,  7'h00},  // still held
        '{REQ_POLL, 16'hFFFF, 1'b0, 5'd0,  7'h00},  // release
        '{REQ_POLL, 16'h7FFF, 1'b0, 5'd0,  7'h00},  // last key only
        '{REQ_TICK, 16'hFFFF, 1'b0, 5'd0,  7'h00},
        '{REQ_TICK, 16'hFFFF, 1'b0, 5'd0,  7'h00},
        '{REQ_TICK, 16'hFFFF, 1'b0, 5'd0,  7'h00},
        '{REQ_POLL, 16'h7FFF, 1'b1, 5'd16, 7'h30},  // last key confirmed as '0'
        '{REQ_POLL, 16'hFFFE, 1'b0, 5'd0,  7'h00},  // other key while pressed
        '{REQ_POLL, 16'hFFDF, 1'b0, 5'd0,  7'h00},
        '{REQ_TICK, 16'h0000, 1'b0, 5'd0,  7'h00},
        '{REQ_POLL, 16'hFFDF, 1'b0, 5'd0,  7'h00},  // too early to confirm
        '{REQ_TICK, 16'h0000, 1'b0, 5'd0,  7'h00},
        '{REQ_TICK, 16'h0000, 1'b0, 5'd0,  7'h00},
        '{REQ_POLL, 16'hFFBF, 1'b0, 5'd0,  7'h00},  // key changed at confirm, dropped
        '{REQ_POLL, 16'hFFBF, 1'b0, 5'd0,  7'h00},
        '{REQ_TICK, 16'hFFFF, 1'b0, 5'd0,  7'h00}
    };

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    in_valid    = 1'b0;
    logic    req_type    = 1'b0;
    levels_t row_levels  = '1;
    logic    out_stall   = 1'b0;
    logic    cfg_wr_en   = 1'b0;
    ticks_t  cfg_wr_data = '0;
    logic    in_stall;
    logic    out_valid;
    code_t   key_code;
    char_t   key_char;

    // hand-written expectation travels with the word it belongs to
    logic    word_typed  = 1'b0;
    code_t   typed_code  = '0;
    char_t   typed_ascii = '0;

    // predictor state
    key_mode_t m_mode  = KM_SCAN;
    code_t     m_held  = '0;
    ticks_t    m_count = '0;
    ticks_t    m_ticks = TICKS_RESET;

    key_report_t awaited_reports[$];

    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_off      = 1'b0;
    int   cur_ticks     = int'(TICKS_RESET);
    int   n_sent        = 0;
    int   n_reports     = 0;
    int   n_errors      = 0;
    int   idle_cycles   = 0;
    int   mixed_ticks   = 0;

    matrix_keypad_debounce u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .row_levels  (row_levels),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .key_code    (key_code),
        .key_char    (key_char),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 clk = ~clk;

    task automatic log_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // lowest column first, then lowest row; 0 when no key is down
    function automatic code_t lowest_key(input levels_t lv);
        int col;
        int row;
        int pos;
        for (col = 0; col < COLS_DEF; col++)
        begin
            for (row = 0; row < ROWS_DEF; row++)
            begin
                pos = col * ROWS_DEF + row;
                if (pos < LEVELS_W && !lv[pos])
                    return code_t'(pos + 1);
            end
        end
        return '0;
    endfunction

    // advance the debounce state by one word and give the result it produces
    function automatic key_report_t next_key_report(input logic kind, input levels_t lv);
        key_report_t r;
        code_t       code;
        r = '0;
        code = lowest_key(lv);
        if (kind == REQ_TICK)
        begin
            if (m_count != 0)
                m_count = m_count - 1'b1;
        end
        else
        begin
            case (m_mode)
                KM_CONFIRM:
                begin
                    // only a poll after the countdown has run out decides
                    if (m_count == 0)
                    begin
                        if (code == m_held)
                        begin
                            r.code = code;
                            m_mode = KM_PRESSED;
                        end
                        else
                            m_mode = KM_SCAN;
                    end
                end
                KM_PRESSED:
                begin
                    if (code != m_held)
                        m_mode = KM_SCAN;
                end
                default:
                begin
                    m_mode  = KM_SCAN;
                    m_count = '0;
                    if (code != 0)
                    begin
                        m_count = m_ticks;
                        m_held  = code;
                        m_mode  = KM_CONFIRM;
                    end
                end
            endcase
        end
        r.ascii = (r.code <= 16) ? KEY_ASCII[r.code] : '0;
        return r;
    endfunction

    // row levels that decode to key position pos, with random levels above it
    function automatic levels_t key_levels(input int pos);
        levels_t lv;
        lv = levels_t'($urandom) | levels_t'((32'd1 << pos) - 32'd1);
        lv[pos] = 1'b0;
        return lv;
    endfunction

    // receiver: random stall, forced high during a hold-off stretch
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    // monitor: check results against the oldest expectation, then predict new words
    always @(posedge clk)
    begin
        key_report_t seen;
        key_report_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.code  = key_code;
                seen.ascii = key_char;
                if (awaited_reports.size() == 0)
                    log_mismatch($sformatf("result code %0d with nothing awaited", key_code));
                else
                begin
                    want = awaited_reports.pop_front();
                    if (seen.code !== want.code)
                        log_mismatch($sformatf("key_code got %0d expected %0d",
                                               seen.code, want.code));
                    if (seen.ascii !== want.ascii)
                        log_mismatch($sformatf("key_char got 0x%02h expected 0x%02h",
                                               seen.ascii, want.ascii));
                end
            end
            if (cfg_wr_en)
                m_ticks = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                want = next_key_report(req_type, row_levels);
                if (word_typed)
                begin
                    want.code  = typed_code;
                    want.ascii = typed_ascii;
                end
                if (want.code != 0)
                    n_reports++;
                awaited_reports.push_back(want);
            end
        end
    end

    // watchdog: any accepted word or register write counts as progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, awaited_reports.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // offer one word and hold it until accepted; valid stays high for a following word
    task automatic send_word(input logic kind, input levels_t lv, input logic typed,
                             input code_t code, input char_t ascii);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= kind;
        row_levels  <= lv;
        word_typed  <= typed;
        typed_code  <= code;
        typed_ascii <= ascii;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic send_plain(input logic kind, input levels_t lv);
        send_word(kind, lv, 1'b0, '0, '0);
    endtask

    // stop offering and wait until every awaited result has come back
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_ticks(input ticks_t v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_ticks = int'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // one key press: press, bounce, count down, confirm, hold, release
    task automatic press_key(input int pos, input int n_ticks, input bit same_key);
        int      n_bounce;
        int      n_hold;
        int      other;
        levels_t lv;
        n_bounce = $urandom_range(2);
        n_hold   = $urandom_range(2);
        other    = $urandom_range(15);
        send_plain(REQ_POLL, key_levels(pos));
        // bounce polls while the countdown runs
        repeat (n_bounce)
            send_plain(REQ_POLL, levels_t'($urandom));
        repeat (n_ticks)
            send_plain(REQ_TICK, levels_t'($urandom));
        // the confirming poll, now and then with a different key
        send_plain(REQ_POLL, same_key ? key_levels(pos) : key_levels(other));
        repeat (n_hold)
            send_plain(REQ_POLL, key_levels(pos));
        lv = ($urandom_range(1) == 0) ? levels_t'(16'hFFFF) : levels_t'($urandom);
        send_plain(REQ_POLL, lv);
    endtask

    // mostly whole key presses with random content, the rest short or stray words
    task automatic run_words(input int n);
        int stop_at;
        int pick;
        int n_ticks;
        stop_at = n_sent + n;
        while (n_sent < stop_at)
        begin
            pick = $urandom_range(9);
            if (pick < 6)
                n_ticks = cur_ticks;
            else if (pick < 8)
                n_ticks = cur_ticks + $urandom_range(3);
            else
                n_ticks = $urandom_range(cur_ticks);
            if ($urandom_range(99) < 80)
                press_key($urandom_range(15), n_ticks, $urandom_range(9) != 0);
            else
                send_plain(1'($urandom_range(1)), levels_t'($urandom));
        end
    endtask

    task automatic hold_receiver(input int n_cycles);
        hold_off <= 1'b1;
        repeat (n_cycles)
            @(posedge clk);
        hold_off <= 1'b0;
    endtask

    initial
    begin
        int        i;
        stim_row_t row;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset debounce count, no idling
        for (i = 0; i < $size(DIRECTED_WORDS); i++)
        begin
            row = DIRECTED_WORDS[i];
            send_word(row.kind, row.levels, row.typed, row.code, row.ascii);
        end
        drain();

        // zero debounce: the next poll confirms directly
        write_ticks(8'd0);
        run_words(150);
        drain();

        // single tick, sender mostly idle
        send_idle_pct = 74;
        write_ticks(8'd1);
        run_words(150);
        drain();

        // receiver mostly stalled, with one long hold-off while words keep coming
        send_idle_pct = 0;
        stall_pct     = 74;
        write_ticks(8'd2);
        fork
            begin
                repeat (30)
                    @(posedge clk);
                hold_receiver(80);
            end
            run_words(150);
        join
        drain();

        // largest debounce count: one full press plus stray words
        send_idle_pct = 34;
        stall_pct     = 34;
        write_ticks(8'd255);
        press_key($urandom_range(15), 255, 1'b1);
        repeat (20)
            send_plain(1'($urandom_range(1)), levels_t'($urandom));
        drain();

        // a random small count, both sides idling
        mixed_ticks = $urandom_range(4);
        write_ticks(ticks_t'(mixed_ticks));
        run_words(150);
        drain();

        repeat (10)
            @(posedge clk);

        $display("run covered %0d words under four idling patterns, %0d key reports",
                 n_sent, n_reports);
        $display("debounce counts used: 3 from reset, 0, 1, 2, 255 and %0d", mixed_ticks);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
